// ===== sv/percent_decoder_stream_unit_defines.svh =====
// Assertion helpers for the percent decoder stream unit.
`ifndef PERCENT_DECODER_STREAM_UNIT_DEFINES_SVH
`define PERCENT_DECODER_STREAM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDSU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/pds_pkg.sv =====
package pds_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Bytes produced by one input item, oldest in slot 0.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            last;
  } pds_group_t;

  // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b0, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b0, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== sv/pds_front.sv =====
module pds_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output pds_pkg::pds_group_t grp_o,
  output logic                grp_push_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [4:0]      b_hex, h_hex;
  logic            b_is_pct;
  logic            accept;
  logic [2:0][7:0] data;
  logic [1:0]      mcnt, cnt;
  logic [1:0]      phase_n;

  assign accept   = push_i && !full_i;
  assign b_hex    = pds_pkg::hex_value(in_byte_i);
  assign h_hex    = pds_pkg::hex_value(held_q);
  assign b_is_pct = (in_byte_i == pds_pkg::PCT_CHAR);

  always_comb begin
    data    = '0;
    mcnt    = 2'd0;
    phase_n = PH_IDLE;
    held_d  = held_q;
    case (phase_q)
      PH_PCT: begin
        if (!b_hex[4]) begin
          held_d  = in_byte_i;
          phase_n = PH_DIGIT;
        end else begin
          data[0] = pds_pkg::PCT_CHAR;
          if (b_is_pct) begin
            phase_n = PH_PCT;
            mcnt    = 2'd1;
          end else begin
            data[1] = in_byte_i;
            mcnt    = 2'd2;
          end
        end
      end
      PH_DIGIT: begin
        if (!b_hex[4] && !h_hex[4]) begin
          data[0] = {h_hex[3:0], b_hex[3:0]};
          mcnt    = 2'd1;
        end else begin
          // Malformed escape: the held digit is plain text again.
          data[0] = pds_pkg::PCT_CHAR;
          data[1] = held_q;
          if (b_is_pct) begin
            phase_n = PH_PCT;
            mcnt    = 2'd2;
          end else begin
            data[2] = in_byte_i;
            mcnt    = 2'd3;
          end
        end
      end
      default: begin
        if (b_is_pct) begin
          phase_n = PH_PCT;
        end else begin
          data[0] = in_byte_i;
          mcnt    = 2'd1;
        end
      end
    endcase

    cnt     = mcnt;
    phase_d = phase_n;
    if (in_last_i) begin
      // End of string: whatever is still pending goes out literally.
      if (phase_n == PH_PCT) begin
        case (mcnt)
          2'd0:    data[0] = pds_pkg::PCT_CHAR;
          2'd1:    data[1] = pds_pkg::PCT_CHAR;
          default: data[2] = pds_pkg::PCT_CHAR;
        endcase
        cnt = mcnt + 2'd1;
      end else if (phase_n == PH_DIGIT) begin
        data[0] = pds_pkg::PCT_CHAR;
        data[1] = in_byte_i;
        cnt     = 2'd2;
      end
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign grp_o.data  = data;
  assign grp_o.count = cnt;
  assign grp_o.last  = in_last_i;
  assign grp_push_o  = accept && (cnt != 2'd0);

endmodule

// ===== sv/pds_queue.sv =====
module pds_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  pds_pkg::pds_group_t wr_data_i,
  input  logic                rd_en_i,
  output pds_pkg::pds_group_t rd_data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  pds_pkg::pds_group_t mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/pds_back.sv =====
module pds_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pds_pkg::pds_group_t head_i,
  input  logic                head_empty_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                deq_o
);

  logic [1:0] idx_q, idx_d;
  logic       last_slot;
  logic       take;

  assign empty_o   = head_empty_i;
  assign take      = pop_i && !head_empty_i;
  assign last_slot = (idx_q == head_i.count - 2'd1);
  assign deq_o     = take && last_slot;

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = head_i.data[0];
      2'd1:    out_byte_o = head_i.data[1];
      default: out_byte_o = head_i.data[2];
    endcase
  end

  assign out_last_o = head_i.last && last_slot;

  always_comb begin
    idx_d = idx_q;
    if (deq_o) begin
      idx_d = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== sv/percent_decoder_stream_unit.sv =====
// Streaming URL percent decoder.
// Input side is a queue write port: drive in_byte_i and in_last_i with push high;
// the byte is taken on a rising edge where full is low. One byte per cycle is taken
// while the internal group queue has room.
// Output side is a queue read port: while empty is low, out_byte_o and out_last_o
// show the oldest decoded byte; it is taken on an edge where pop is high.
// Each input byte yields zero to three decoded bytes, written as one group into a
// QUEUE_DEPTH-entry queue; the back end hands them out one per pop.
// A decoded byte enters the group queue on the edge that takes the input byte that
// completes it. Input flows at one byte per cycle while the queue has room; output
// is bounded by one decoded byte per cycle: the back end gives one byte per pop.
// A stalled receiver fills the queue; full then rises and input is held off, with
// no byte lost. Reset clears the escape state and empties the queue; no item
// is accepted before reset is released.
`include "percent_decoder_stream_unit_defines.svh"

module percent_decoder_stream_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  pds_pkg::pds_group_t grp, head;
  logic                grp_push;
  logic                q_empty;
  logic                deq;

  pds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .grp_o      (grp),
    .grp_push_o (grp_push)
  );

  pds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (grp_push),
    .wr_data_i (grp),
    .rd_en_i   (deq),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  pds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (q_empty),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .deq_o        (deq)
  );

  // A string's final byte always leaves something to deliver.
  `PDSU_ASSERT_NOW(a_last_pushes, clk_i, rst_ni, push && !full && in_last_i, grp_push)
  // Groups written into the queue are never empty.
  `PDSU_ASSERT_NOW(a_group_nonempty, clk_i, rst_ni, grp_push, grp.count != 2'd0)
  // Taking a byte that is not the end of its group leaves the rest on show.
  `PDSU_ASSERT_NEXT(a_group_stays, clk_i, rst_ni, pop && !empty && !deq, !empty)

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  localparam logic [7:0] PCT_CHAR = pds_pkg::PCT_CHAR;

  localparam int RANDOM_ITEMS = 235;
  localparam int CYCLE_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 40;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT,
    ESC_DIGIT
  } esc_state_e;

  // One item of stimulus. When typed is set, n and e0..e2 give the decoded bytes
  // that the item must produce, oldest first.
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  localparam stim_row_t DIRECTED [25] = '{
    '{8'h00,    1'b0, 1'b1, 2'd1, 8'h00,    8'h00, 8'h00},
    '{8'hFF,    1'b0, 1'b1, 2'd1, 8'hFF,    8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"4",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"1",      1'b0, 1'b1, 2'd1, "A",      8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"f",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"F",      1'b0, 1'b1, 2'd1, 8'hFF,    8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"g",      1'b0, 1'b1, 2'd2, PCT_CHAR, "g",   8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"0",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"z",      1'b0, 1'b1, 2'd3, PCT_CHAR, "0",   "z"},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00},
    '{"7",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd2, PCT_CHAR, "7",   8'h00},
    '{"9",      1'b1, 1'b1, 2'd2, PCT_CHAR, "9",   8'h00},
    '{PCT_CHAR, 1'b1, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00},
    '{"a",      1'b1, 1'b1, 2'd1, "a",      8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"A",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"0",      1'b1, 1'b1, 2'd1, 8'hA0,    8'h00, 8'h00},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00},
    '{"@",      1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00}
  };

  localparam string HEX_CHARS  = "0123456789ABCDEFabcdef";
  localparam string NEAR_CHARS = "/:@G`g%%";

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic       pop       = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  logic       calm = 1'b0;
  stim_row_t  cur_row = '0;
  int         cycle_count = 0;
  int         mismatches = 0;

  esc_state_e esc_state = ESC_NONE;
  logic [7:0] held_char = 8'h00;
  decoded_t   awaited_bytes[$];

  percent_decoder_stream_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Digits keep their low nibble; both letter cases sit 9 above theirs.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c <= "9") begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] pick_hex();
    return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_near_hex();
    return NEAR_CHARS[$urandom_range(0, NEAR_CHARS.len() - 1)];
  endfunction

  // Decodes one input byte, updating the escape state; outs[0] is the oldest byte.
  function automatic void decode_step(input logic [7:0] b, input logic l,
                                      output logic [2:0][7:0] outs, output int n);
    bit rescan;
    rescan = 1'b0;
    outs = '0;
    n = 0;
    case (esc_state)
      ESC_PCT: begin
        if (is_hex(b)) begin
          held_char = b;
          esc_state = ESC_DIGIT;
        end else begin
          outs[n] = PCT_CHAR;
          n++;
          rescan = 1'b1;
        end
      end
      ESC_DIGIT: begin
        if (is_hex(b)) begin
          outs[n] = {nibble_of(held_char), nibble_of(b)};
          n++;
          esc_state = ESC_NONE;
        end else begin
          outs[n] = PCT_CHAR;
          outs[n + 1] = held_char;
          n += 2;
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase
    if (rescan) begin
      if (b == PCT_CHAR) begin
        esc_state = ESC_PCT;
      end else begin
        esc_state = ESC_NONE;
        outs[n] = b;
        n++;
      end
    end
    if (l) begin
      if (esc_state == ESC_PCT) begin
        outs[n] = PCT_CHAR;
        n++;
      end else if (esc_state == ESC_DIGIT) begin
        outs[n] = PCT_CHAR;
        outs[n + 1] = held_char;
        n += 2;
      end
      esc_state = ESC_NONE;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_row(input stim_row_t r);
    while (!calm && $urandom_range(0, 99) < 9) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    cur_row = r;
    push <= 1'b1;
    in_byte_i <= r.b;
    in_last_i <= r.l;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    pop <= calm || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk_i) begin : scoreboard
    logic [2:0][7:0] got;
    int n;
    decoded_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && push && !full) begin
      decode_step(in_byte_i, in_last_i, got, n);
      if (cur_row.typed) begin
        got = {cur_row.e2, cur_row.e1, cur_row.e0};
        n = cur_row.n;
      end
      for (int k = 0; k < n; k++) begin
        awaited_bytes.push_back('{got[k], in_last_i && (k == n - 1)});
      end
    end
    if (rst_ni && pop && !empty) begin
      if (awaited_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte_o, out_last_o));
      end else begin
        want = awaited_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          report_mismatch($sformatf("byte %02h, wanted %02h", out_byte_o, want.data));
        end
        if (out_last_o !== want.last) begin
          report_mismatch($sformatf("last %0b, wanted %0b", out_last_o, want.last));
        end
      end
    end
  end

  initial begin
    logic [7:0] text[$];
    stim_row_t row;
    int pieces;
    int pick;
    int random_sent;
    random_sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      send_row(DIRECTED[i]);
    end

    // Mostly whole strings built from escapes, with broken escapes and loose bytes mixed in.
    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= 100 && random_sent < 170);
      text.delete();
      pieces = $urandom_range(1, 5);
      repeat (pieces) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          text.push_back(PCT_CHAR);
          text.push_back(pick_hex());
          text.push_back(pick_hex());
        end else if (pick < 60) begin
          text.push_back(PCT_CHAR);
          if ($urandom_range(0, 1) == 1) begin
            text.push_back(pick_hex());
          end
          if ($urandom_range(0, 2) != 0) begin
            text.push_back(pick_near_hex());
          end
        end else if (pick < 85) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else begin
          text.push_back(pick_near_hex());
        end
      end
      foreach (text[i]) begin
        row = '0;
        row.b = text[i];
        row.l = (i == text.size() - 1);
        send_row(row);
        random_sent++;
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (awaited_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_bytes.size() != 0) begin
      report_mismatch("decoded bytes never arrived");
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/pds_pkg.sv
sv/pds_front.sv
sv/pds_queue.sv
sv/pds_back.sv
sv/percent_decoder_stream_unit.sv
tb/sv/testbench.sv
